// ===== hw/rtl/ilb_pkg.sv =====
// ilb_pkg: shared types and constants for the indexed list buffer
// no dependencies; used by ilb_cell, ilb_scan and indexed_list_buffer
package ilb_pkg;

  localparam int ACTION_W   = 4;
  localparam int POS_W      = 6;
  localparam int VALUE_W    = 32;
  localparam int FOUND_W    = 6;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 7;
  // cells examined per scan cycle
  localparam int GROUP_SIZE = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND     = 4'd0,
    ACT_PUSH_FRONT = 4'd1,
    ACT_POP_BACK   = 4'd2,
    ACT_POP_FRONT  = 4'd3,
    ACT_INSERT     = 4'd4,
    ACT_REMOVE     = 4'd5,
    ACT_SET        = 4'd6,
    ACT_READ       = 4'd7,
    ACT_FIND       = 4'd8,
    ACT_CLEAR      = 4'd9,
    ACT_PEEK_FRONT = 4'd10,
    ACT_PEEK_BACK  = 4'd11
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // update broadcast to every cell
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic write;
  } ilb_cmd_t;

  // scanner status seen by the controller
  typedef struct packed {
    logic done;
    logic found;
  } ilb_scan_t;

endpackage

// ===== hw/rtl/ilb_cell.sv =====
// ilb_cell: one list entry; takes the new word, its left or right neighbor, or holds
// depends on ilb_pkg for the update command type
module ilb_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6
) (
  input  logic                   clk,
  input  ilb_pkg::ilb_cmd_t      cmd,
  input  logic [IW-1:0]          pos,
  input  logic [DATA_WIDTH-1:0]  item,
  input  logic [DATA_WIDTH-1:0]  left_data,
  input  logic [DATA_WIDTH-1:0]  right_data,
  output logic [DATA_WIDTH-1:0]  data,
  output logic                   match
);
  import ilb_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.write && pos == MY_IDX) begin
      data <= item;
    end else if (cmd.shift_up && MY_IDX > pos) begin
      data <= left_data;
    end else if (cmd.shift_down && MY_IDX >= pos) begin
      data <= right_data;
    end
  end

  assign match = (data == item);

endmodule

// ===== hw/rtl/ilb_scan.sv =====
// ilb_scan: walks the cells one group per cycle to pick a word and find the first match
// depends on ilb_pkg for the group size and the status struct
module ilb_scan #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [$clog2(CAPACITY)-1:0]           rd_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]         count,
  input  logic [DATA_WIDTH-1:0]                 cell_data [CAPACITY],
  input  logic [CAPACITY-1:0]                   match,
  output ilb_pkg::ilb_scan_t                    stat,
  output logic [DATA_WIDTH-1:0]                 value,
  output logic [$clog2(CAPACITY)-1:0]           found_idx
);
  import ilb_pkg::*;

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY+1);
  localparam int NG  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int GB  = $clog2(GROUP_SIZE);
  localparam int PW  = GW + GB;
  localparam int PAD = NG * GROUP_SIZE;
  localparam int AW  = $clog2(PAD);

  logic [DATA_WIDTH-1:0] data_pad [PAD];
  logic [PAD-1:0]        hit_pad;
  logic [DATA_WIDTH-1:0] grp_data [GROUP_SIZE];
  logic [GROUP_SIZE-1:0] grp_hit;
  logic [GB-1:0]         hit_k;
  logic                  hit_any;
  logic [GW-1:0]         grp;
  logic                  busy;
  logic                  found;
  logic                  last;
  logic [PW-1:0]         rd_pad;

  // only entries below the count take part in a search
  for (genvar i = 0; i < PAD; i++) begin : g_pad
    if (i < CAPACITY) begin : g_real
      assign data_pad[i] = cell_data[i];
      assign hit_pad[i]  = match[i] && (CW'(i) < count);
    end else begin : g_fill
      assign data_pad[i] = '0;
      assign hit_pad[i]  = 1'b0;
    end
  end

  always_comb begin
    logic [PW-1:0] fi;
    fi = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      fi          = {grp, GB'(k)};
      grp_data[k] = data_pad[fi[AW-1:0]];
      grp_hit[k]  = hit_pad[fi[AW-1:0]];
    end
  end

  // lowest hit in the current group
  always_comb begin
    hit_any = |grp_hit;
    hit_k   = '0;
    for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
      if (grp_hit[k]) hit_k = GB'(k);
    end
  end

  assign rd_pad     = PW'(rd_addr);
  assign last       = (grp == GW'(NG - 1));
  assign stat.done  = busy && last;
  assign stat.found = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      found <= 1'b0;
      grp   <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      found <= 1'b0;
      grp   <= '0;
    end else if (busy) begin
      if (hit_any) found <= 1'b1;
      if (last) begin
        busy <= 1'b0;
      end else begin
        grp <= grp + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (!found && hit_any) found_idx <= IW'({grp, hit_k});
      if (grp == rd_pad[PW-1:GB]) value <= grp_data[rd_pad[GB-1:0]];
    end
  end

endmodule

// ===== hw/rtl/indexed_list_buffer.sv =====
// indexed_list_buffer: fixed-capacity ordered list held in a row of shifting cells
// flow: a request is registered when taken; reads, pops, peeks, remove and find then pass through
//   S_SCAN while the scanner walks the cells, and the result is written from S_FINISH;
//   one request in work at a time, the next taken after its result
// reset: count cleared and the output emptied at once; entries are undefined until written
// depends on ilb_pkg, ilb_cell and ilb_scan
module indexed_list_buffer #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ilb_pkg::ACTION_W-1:0]  action,
  input  logic [ilb_pkg::POS_W-1:0]     position,
  input  logic [ilb_pkg::VALUE_W-1:0]   item_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ilb_pkg::VALUE_W-1:0]   read_value,
  output logic [ilb_pkg::FOUND_W-1:0]   found_position,
  output logic [ilb_pkg::STATUS_W-1:0]  status,
  output logic [ilb_pkg::COUNT_W-1:0]   entry_count
);
  import ilb_pkg::*;

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY+1);
  localparam int CMP_W = CW + POS_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH-1:0] item;
  ilb_cmd_t              upd_cmd;
  logic [IW-1:0]         upd_pos;
  logic [IW-1:0]         rd_addr;
  logic                  need_rd;
  logic                  is_find;
  status_t               pend_status;
  logic [CW-1:0]         pend_count;

  // request decode against the current count
  status_t               d_status;
  ilb_cmd_t              d_cmd;
  logic [IW-1:0]         d_pos;
  logic [IW-1:0]         d_rd;
  logic                  d_need_rd;
  logic                  d_find;
  logic [CW-1:0]         d_count;
  logic                  full;
  logic                  empty;
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      cnt_c;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  ilb_cmd_t              cell_cmd;
  ilb_scan_t             scan_stat;
  logic [DATA_WIDTH-1:0] scan_value;
  logic [IW-1:0]         scan_idx;
  logic                  scan_start;
  logic                  fire;

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count);

  always_comb begin
    d_status  = ST_OK;
    d_cmd     = '0;
    d_pos     = IW'(position);
    d_rd      = '0;
    d_need_rd = 1'b0;
    d_find    = 1'b0;
    d_count   = count;
    case (action_t'(action))
      ACT_APPEND: begin
        if (full) begin
          d_status = ST_FULL;
        end else begin
          d_cmd.write = 1'b1;
          d_pos       = IW'(count);
          d_count     = count + CW'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          d_status = ST_FULL;
        end else begin
          d_cmd.shift_up = 1'b1;
          d_cmd.write    = 1'b1;
          d_pos          = '0;
          d_count        = count + CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else begin
          d_rd      = IW'(count - CW'(1));
          d_need_rd = 1'b1;
          d_count   = count - CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else begin
          d_cmd.shift_down = 1'b1;
          d_pos            = '0;
          d_need_rd        = 1'b1;
          d_count          = count - CW'(1);
        end
      end
      ACT_INSERT: begin
        if (pos_c > cnt_c) begin
          d_status = ST_RANGE;
        end else if (full) begin
          d_status = ST_FULL;
        end else begin
          d_cmd.shift_up = 1'b1;
          d_cmd.write    = 1'b1;
          d_count        = count + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (pos_c >= cnt_c) begin
          d_status = ST_RANGE;
        end else begin
          d_cmd.shift_down = 1'b1;
          d_rd             = IW'(position);
          d_need_rd        = 1'b1;
          d_count          = count - CW'(1);
        end
      end
      ACT_SET: begin
        if (pos_c >= cnt_c) begin
          d_status = ST_RANGE;
        end else begin
          d_cmd.write = 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_c >= cnt_c) begin
          d_status = ST_RANGE;
        end else begin
          d_rd      = IW'(position);
          d_need_rd = 1'b1;
        end
      end
      ACT_FIND: begin
        d_find = 1'b1;
      end
      ACT_CLEAR: begin
        d_count = '0;
      end
      ACT_PEEK_FRONT: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else begin
          d_need_rd = 1'b1;
        end
      end
      ACT_PEEK_BACK: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else begin
          d_rd      = IW'(count - CW'(1));
          d_need_rd = 1'b1;
        end
      end
      default: begin
        d_status = ST_OK;
      end
    endcase
  end

  assign in_stall   = (state != S_IDLE);
  assign scan_start = (state == S_IDLE) && in_valid && (d_need_rd || d_find);
  // the list changes in the same cycle the result is written
  assign fire       = (state == S_FINISH) && (!out_valid || !out_stall);
  assign cell_cmd   = fire ? upd_cmd : '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = cell_data[i];
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end
    ilb_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .pos        (upd_pos),
      .item       (item),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  ilb_scan #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .rd_addr   (rd_addr),
    .count     (count),
    .cell_data (cell_data),
    .match     (cell_match),
    .stat      (scan_stat),
    .value     (scan_value),
    .found_idx (scan_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_valid && !out_stall && !fire) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item        <= DATA_WIDTH'(item_value);
            upd_cmd     <= d_cmd;
            upd_pos     <= d_pos;
            rd_addr     <= d_rd;
            need_rd     <= d_need_rd;
            is_find     <= d_find;
            pend_status <= d_status;
            pend_count  <= d_count;
            state       <= (d_need_rd || d_find) ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if (scan_stat.done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (fire) begin
            out_valid   <= 1'b1;
            read_value  <= need_rd ? VALUE_W'(scan_value) : '0;
            entry_count <= COUNT_W'(pend_count);
            if (is_find) begin
              status         <= scan_stat.found ? ST_OK : ST_NOTFOUND;
              found_position <= scan_stat.found ? FOUND_W'(scan_idx) : '0;
            end else begin
              status         <= pend_status;
              found_position <= '0;
            end
            count <= pend_count;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for indexed_list_buffer, the ordered list of data words
// a local list model predicts every result; directed, fill/drain, random and backpressure tests
// depends on ilb_pkg and indexed_list_buffer
module tb;
  import ilb_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_SLACK  = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd12;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [FOUND_W-1:0]  found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] req_action = '0;
  logic [POS_W-1:0] req_position = '0;
  logic [VALUE_W-1:0] req_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VALUE_W-1:0] res_value;
  logic [FOUND_W-1:0] res_found;
  logic [STATUS_W-1:0] res_status;
  logic [COUNT_W-1:0] res_count;

  logic [VALUE_W-1:0] list_mem [LIST_DEPTH];
  int list_len = 0;
  list_result_t pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  indexed_list_buffer #(
    .CAPACITY(LIST_DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(req_action),
    .position(req_position),
    .item_value(req_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(res_value),
    .found_position(res_found),
    .status(res_status),
    .entry_count(res_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold counted down here
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: value %h pos %0d status %0d count %0d",
                 $time, res_value, res_found, res_status, res_count);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_value !== exp_res.value) begin
          $display("%0t: read_value expected %h got %h", $time, exp_res.value, res_value);
          mismatches++;
        end
        if (res_found !== exp_res.found) begin
          $display("%0t: found_position expected %0d got %0d", $time, exp_res.found,
                   res_found);
          mismatches++;
        end
        if (res_status !== exp_res.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_res.status, res_status);
          mismatches++;
        end
        if (res_count !== exp_res.count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, exp_res.count,
                   res_count);
          mismatches++;
        end
      end
    end
  end

  // applies one request to the local list and returns what the block must answer
  function automatic list_result_t apply_list_request(logic [ACTION_W-1:0] act,
                                                      logic [POS_W-1:0] pos,
                                                      logic [VALUE_W-1:0] val);
    list_result_t r;
    int i;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_APPEND: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      ACT_PUSH_FRONT: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          for (i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = val;
          list_len++;
        end
      end
      ACT_POP_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          list_len--;
          r.value = list_mem[list_len];
        end
      end
      ACT_POP_FRONT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          r.value = list_mem[0];
          for (i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ACT_INSERT: begin
        if (pos > list_len) r.status = ST_RANGE;
        else if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else begin
          r.value = list_mem[pos];
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ACT_SET: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else list_mem[pos] = val;
      end
      ACT_READ: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.value = list_mem[pos];
      end
      ACT_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (r.status == ST_NOTFOUND && list_mem[i] == val) begin
            r.found = i[FOUND_W-1:0];
            r.status = ST_OK;
          end
        end
      end
      ACT_CLEAR: list_len = 0;
      ACT_PEEK_FRONT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.value = list_mem[0];
      end
      ACT_PEEK_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.value = list_mem[list_len-1];
      end
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_action <= act;
    req_position <= pos;
    req_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_list_request(act, pos, val));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly in-range or one-past-the-end positions, sometimes anything
  function automatic logic [POS_W-1:0] random_position();
    int p;
    if (list_len > 0 && $urandom_range(9) < 8) begin
      p = $urandom_range(list_len);
      if (p > LIST_DEPTH - 1) p = LIST_DEPTH - 1;
      return p[POS_W-1:0];
    end
    return POS_W'($urandom_range(LIST_DEPTH - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] search_word();
    if (list_len > 0 && $urandom_range(9) < 7) return list_mem[$urandom_range(list_len - 1)];
    return random_word();
  endfunction

  task automatic send_random_request();
    int r;
    logic [ACTION_W-1:0] act;
    r = $urandom_range(99);
    if (r < 14) act = ACT_APPEND;
    else if (r < 24) act = ACT_PUSH_FRONT;
    else if (r < 32) act = ACT_POP_BACK;
    else if (r < 40) act = ACT_POP_FRONT;
    else if (r < 50) act = ACT_INSERT;
    else if (r < 58) act = ACT_REMOVE;
    else if (r < 66) act = ACT_SET;
    else if (r < 74) act = ACT_READ;
    else if (r < 84) act = ACT_FIND;
    else if (r < 86) act = ACT_CLEAR;
    else if (r < 90) act = ACT_PEEK_FRONT;
    else if (r < 94) act = ACT_PEEK_BACK;
    else act = ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    send_request(act, random_position(), (act == ACT_FIND) ? search_word() : random_word());
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // reads, removals, set, find and an out-of-range insert on the empty list
    send_request(ACT_POP_BACK, '0, '0);
    send_request(ACT_POP_FRONT, '0, '0);
    send_request(ACT_PEEK_FRONT, '0, '0);
    send_request(ACT_PEEK_BACK, '0, '0);
    send_request(ACT_READ, '0, '0);
    send_request(ACT_REMOVE, '1, '0);
    send_request(ACT_SET, '0, '1);
    send_request(ACT_FIND, '0, '0);
    send_request(ACT_INSERT, 6'd1, '1);
    // insert at the end position acts as append
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_APPEND, '0, '1);
    send_request(ACT_PUSH_FRONT, '0, 32'h5a5a_5a5a);
    send_request(ACT_INSERT, 6'd1, 32'ha5a5_a5a5);
    send_request(ACT_READ, 6'd3, '0);
    send_request(ACT_SET, '0, 32'h1234_5678);
    send_request(ACT_FIND, '0, '1);
    send_request(ACT_FIND, '0, 32'h0000_0001);
    send_request(ACT_REMOVE, 6'd1, '0);
    send_request(ACT_PEEK_FRONT, '0, '0);
    send_request(ACT_PEEK_BACK, '0, '0);
    send_request(ACT_UNUSED_LO, '0, '0);
    send_request(ACT_UNUSED_HI, '1, '1);
    send_request(ACT_POP_FRONT, '0, '0);
    send_request(ACT_POP_BACK, '0, '0);
    send_request(ACT_CLEAR, '0, '0);
    wait_drained();
  endtask

  task automatic test_fill_and_drain();
    int r;
    send_idle_pct = 24;
    recv_stall_pct = 24;
    while (list_len < LIST_DEPTH) begin
      r = $urandom_range(2);
      if (r == 0) send_request(ACT_APPEND, POS_W'($urandom), $urandom);
      else if (r == 1) send_request(ACT_PUSH_FRONT, POS_W'($urandom), $urandom);
      else send_request(ACT_INSERT, POS_W'($urandom_range(list_len)), $urandom);
    end
    // full list: every growing request is refused, then reads, set, finds and peeks
    send_request(ACT_APPEND, '0, random_word());
    send_request(ACT_PUSH_FRONT, '0, random_word());
    send_request(ACT_INSERT, '0, random_word());
    send_request(ACT_INSERT, '1, random_word());
    send_request(ACT_READ, '1, '0);
    send_request(ACT_SET, '1, random_word());
    send_request(ACT_FIND, '0, list_mem[LIST_DEPTH-1]);
    send_request(ACT_FIND, '0, list_mem[0]);
    send_request(ACT_PEEK_FRONT, '0, '0);
    send_request(ACT_PEEK_BACK, '0, '0);
    while (list_len > 0) begin
      r = $urandom_range(2);
      if (r == 0) send_request(ACT_POP_BACK, POS_W'($urandom), $urandom);
      else if (r == 1) send_request(ACT_POP_FRONT, POS_W'($urandom), $urandom);
      else send_request(ACT_REMOVE, POS_W'($urandom_range(list_len - 1)), $urandom);
    end
    wait_drained();
  endtask

  task automatic test_random_mix(input int items, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_random_request();
    wait_drained();
  endtask

  // output held off long enough that the block stops taking requests
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (20) send_random_request();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random_mix(70, 0, 0);
    test_random_mix(70, 58, 0);
    test_random_mix(70, 0, 58);
    test_random_mix(70, 24, 24);
    test_backpressure();
    test_random_mix(40, 24, 24);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== indexed_list_buffer.f =====
hw/rtl/ilb_pkg.sv
hw/rtl/ilb_cell.sv
hw/rtl/ilb_scan.sv
hw/rtl/indexed_list_buffer.sv
test/tb.sv
